// File: rtl/pre_pkg.sv
// pre_pkg: shared types and constants of the page replacement engine
// no dependencies; used by page_replacement_engine
package pre_pkg;

    localparam int FRAME_SLOTS = 16;
    localparam int SEQ_DEPTH   = 1024;
    localparam int PAGE_BITS   = 16;

    localparam int ADDR_W  = $clog2(SEQ_DEPTH);
    localparam int CNT_W   = ADDR_W + 1;
    localparam int FRM_W   = $clog2(FRAME_SLOTS);
    localparam int NUM_W   = FRM_W + 1;
    localparam int CFG_W   = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [CNT_W-1:0] NEVER     = '1;

    localparam logic [1:0] K_APPEND  = 2'd0;
    localparam logic [1:0] K_STEP    = 2'd1;
    localparam logic [1:0] K_RESTART = 2'd2;

    localparam logic [2:0] P_FIFO  = 3'd0;
    localparam logic [2:0] P_LRU   = 3'd1;
    localparam logic [2:0] P_OPT   = 3'd2;
    localparam logic [2:0] P_NRU   = 3'd3;
    localparam logic [2:0] P_SC    = 3'd4;
    localparam logic [2:0] P_CLOCK = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 1'd1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] page;
    } t_in;

    typedef struct packed {
        logic        hit;
        logic [3:0]  frame;
        logic        evicted_valid;
        logic [15:0] evicted_page;
        logic [15:0] ref_page;
        logic [10:0] hit_count;
        logic [10:0] miss_count;
    } t_out;

endpackage

// File: rtl/pre_ram.sv
// pre_ram: generic single-port ram with registered read
// no dependencies
module pre_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/page_replacement_engine.sv
// page_replacement_engine: page-frame replacement simulator over a stored reference string
// depends on pre_pkg and pre_ram
//
// Append and restart transfers are done in the idle state. A step for n frames in use does
// one ram read, a scan of the frames for a hit or free slot, and on eviction a victim scan
// over the frames (second chance adds a clear pass over the frames; clock scans from the
// hand, first taking the frame count off a hand left beyond it as often as it takes). OPT
// adds a lookahead over each stored reference after the current one, which reads the
// single ram port. NRU adds a shift-subtract pass to find the reference count modulo n.
// The input is not ready while a step is in progress; a finished result waits in an output
// register.
module page_replacement_engine (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  pre_pkg::t_in                       i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output pre_pkg::t_out                      o_out_data,
    input  logic                               i_cfg_we,
    input  logic [pre_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pre_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int FS = pre_pkg::FRAME_SLOTS;
    localparam int AW = pre_pkg::ADDR_W;
    localparam int CW = pre_pkg::CNT_W;
    localparam int FW = pre_pkg::FRM_W;
    localparam int NW = pre_pkg::NUM_W;
    localparam int PW = pre_pkg::PAGE_BITS;
    localparam int MW = $clog2(CW + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RD    = 10'b0000000010,
        S_SRCH  = 10'b0000000100,
        S_OPT   = 10'b0000001000,
        S_VIC   = 10'b0000010000,
        S_SCCLR = 10'b0000100000,
        S_CMOD  = 10'b0001000000,
        S_CLK   = 10'b0010000000,
        S_MOD   = 10'b0100000000,
        S_UPD   = 10'b1000000000
    } t_state;

    t_state          r_state;
    logic [2:0]      r_policy;
    logic [4:0]      r_frames;
    logic [CW-1:0]   r_len;
    logic [CW-1:0]   r_pos;
    logic [FS-1:0]   r_fv;
    logic [FS-1:0]   r_rb;
    logic [PW-1:0]   r_fp [FS];
    logic [CW-1:0]   r_lt [FS];
    logic [CW-1:0]   r_lu [FS];
    logic [CW-1:0]   r_nu [FS];
    logic [FW-1:0]   r_hand;
    logic [CW-1:0]   r_hits;
    logic [CW-1:0]   r_miss;
    logic [PW-1:0]   r_pg;
    logic [NW-1:0]   r_idx;
    logic [FW-1:0]   r_dest;
    logic            r_hit;
    logic            r_ev;
    logic            r_free_any;
    logic [FW-1:0]   r_free_idx;
    logic [FW-1:0]   r_v;
    logic [CW-1:0]   r_bk_lt;
    logic [CW-1:0]   r_bk_lu;
    logic [CW-1:0]   r_bk_nu;
    logic            r_bk_rb;
    logic            r_sany;
    logic [FW-1:0]   r_sv;
    logic [CW-1:0]   r_sc_lt;
    logic [CW-1:0]   r_j;
    logic [CW-1:0]   r_jd;
    logic            r_rv;
    logic [NW-1:0]   r_rem;
    logic [CW-1:0]   r_dvd;
    logic [MW-1:0]   r_mcnt;
    logic            r_ov;
    pre_pkg::t_out   r_out;

    logic [NW-1:0]   n_frames;
    logic [FW-1:0]   sel;
    logic            in_fire;
    logic            ram_we;
    logic [AW-1:0]   ram_addr;
    logic [PW-1:0]   ram_rdata;
    logic            better;
    logic            free_now;
    logic [FW-1:0]   free_idx_now;
    logic [NW-1:0]   idx_inc;
    logic [NW-1:0]   rem2;
    t_state          fin_state;
    logic [CW-1:0]   hits_inc;
    logic [CW-1:0]   miss_inc;

    assign n_frames = (r_frames == '0) ? NW'(1) :
                      (r_frames > 5'(FS)) ? NW'(FS) : NW'(r_frames);
    assign sel      = r_idx[FW-1:0];
    assign in_fire  = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    assign ram_we   = (r_state == S_IDLE) && in_fire && (i_in_data.kind == pre_pkg::K_APPEND)
                      && (r_len < CW'(pre_pkg::SEQ_DEPTH));
    assign ram_addr = (r_state == S_IDLE) ?
                      ((i_in_data.kind == pre_pkg::K_APPEND) ? r_len[AW-1:0] : r_pos[AW-1:0])
                      : r_j[AW-1:0];

    pre_ram #(
        .WIDTH (PW),
        .DEPTH (pre_pkg::SEQ_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_in_data.page[PW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign free_now     = r_free_any || !r_fv[sel];
    assign free_idx_now = r_free_any ? r_free_idx : sel;
    assign idx_inc      = (r_idx + NW'(1) == n_frames) ? '0 : r_idx + NW'(1);
    assign rem2         = {r_rem[NW-2:0], r_dvd[CW-1]};
    assign fin_state    = (r_policy == pre_pkg::P_NRU) ? S_MOD : S_UPD;
    assign hits_inc     = (r_hits == pre_pkg::COUNT_MAX) ? r_hits : r_hits + CW'(1);
    assign miss_inc     = (r_miss == pre_pkg::COUNT_MAX) ? r_miss : r_miss + CW'(1);

    always_comb begin
        unique case (r_policy)
            pre_pkg::P_FIFO, pre_pkg::P_SC: better = r_lt[sel] < r_bk_lt;
            pre_pkg::P_LRU: better = (r_lu[sel] < r_bk_lu) ||
                                     (r_lu[sel] == r_bk_lu && r_lt[sel] < r_bk_lt);
            pre_pkg::P_OPT: better = (r_nu[sel] > r_bk_nu) ||
                                     (r_nu[sel] == r_bk_nu && r_lt[sel] < r_bk_lt);
            pre_pkg::P_NRU: better = (!r_rb[sel] && r_bk_rb) ||
                                     (r_rb[sel] == r_bk_rb && r_lu[sel] < r_bk_lu);
            default:        better = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_policy <= pre_pkg::P_FIFO;
            r_frames <= 5'd4;
            r_len    <= '0;
            r_pos    <= '0;
            r_fv     <= '0;
            r_rb     <= '0;
            r_hand   <= '0;
            r_hits   <= '0;
            r_miss   <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    pre_pkg::CFG_POLICY: r_policy <= i_cfg_data[2:0];
                    pre_pkg::CFG_FRAMES: r_frames <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ov && i_out_ready && r_state != S_UPD) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (i_in_data.kind == pre_pkg::K_APPEND) begin
                            if (r_len < CW'(pre_pkg::SEQ_DEPTH)) begin
                                r_len <= r_len + CW'(1);
                            end
                        end else if (i_in_data.kind == pre_pkg::K_RESTART) begin
                            r_fv   <= '0;
                            r_rb   <= '0;
                            r_pos  <= '0;
                            r_hand <= '0;
                            r_hits <= '0;
                            r_miss <= '0;
                        end else if (i_in_data.kind == pre_pkg::K_STEP) begin
                            if (r_pos < r_len) begin
                                r_state <= S_RD;
                            end
                        end
                    end
                end
                S_RD: begin
                    r_pg       <= ram_rdata;
                    r_idx      <= '0;
                    r_hit      <= 1'b0;
                    r_ev       <= 1'b0;
                    r_free_any <= 1'b0;
                    r_rem      <= '0;
                    r_dvd      <= r_pos + CW'(1);
                    r_mcnt     <= '0;
                    r_state    <= S_SRCH;
                end
                S_SRCH: begin
                    if (r_fv[sel] && r_fp[sel] == r_pg) begin
                        r_hit   <= 1'b1;
                        r_dest  <= sel;
                        r_state <= fin_state;
                    end else begin
                        r_free_any <= free_now;
                        r_free_idx <= free_idx_now;
                        if (r_idx == n_frames - NW'(1)) begin
                            if (free_now) begin
                                r_dest  <= free_idx_now;
                                r_state <= fin_state;
                            end else begin
                                r_ev <= 1'b1;
                                if (r_policy == pre_pkg::P_OPT) begin
                                    r_j     <= r_pos + CW'(1);
                                    r_rv    <= 1'b0;
                                    for (int k = 0; k < FS; k++) begin
                                        r_nu[k] <= pre_pkg::NEVER;
                                    end
                                    r_state <= S_OPT;
                                end else if (r_policy == pre_pkg::P_CLOCK) begin
                                    r_idx   <= NW'(r_hand);
                                    r_state <= S_CMOD;
                                end else begin
                                    r_idx   <= '0;
                                    r_sany  <= 1'b0;
                                    r_state <= S_VIC;
                                end
                            end
                        end else begin
                            r_idx <= r_idx + NW'(1);
                        end
                    end
                end
                S_OPT: begin
                    if (r_rv) begin
                        for (int k = 0; k < FS; k++) begin
                            if (NW'(k) < n_frames && r_nu[k] == pre_pkg::NEVER &&
                                r_fp[k] == ram_rdata) begin
                                r_nu[k] <= r_jd;
                            end
                        end
                    end
                    if (r_j < r_len) begin
                        r_j  <= r_j + CW'(1);
                        r_jd <= r_j;
                        r_rv <= 1'b1;
                    end else begin
                        r_rv <= 1'b0;
                        if (!r_rv) begin
                            r_idx   <= '0;
                            r_sany  <= 1'b0;
                            r_state <= S_VIC;
                        end
                    end
                end
                S_VIC: begin
                    if (r_idx == n_frames) begin
                        r_idx <= '0;
                        unique case (r_policy)
                            pre_pkg::P_FIFO, pre_pkg::P_LRU, pre_pkg::P_OPT,
                            pre_pkg::P_NRU: begin
                                r_dest  <= r_v;
                                r_state <= fin_state;
                            end
                            pre_pkg::P_SC: begin
                                r_dest  <= r_sany ? r_sv : r_v;
                                r_state <= S_SCCLR;
                            end
                            default: begin
                                r_dest  <= '0;
                                r_state <= fin_state;
                            end
                        endcase
                    end else begin
                        if (r_idx == '0 || better) begin
                            r_v     <= sel;
                            r_bk_lt <= r_lt[sel];
                            r_bk_lu <= r_lu[sel];
                            r_bk_nu <= r_nu[sel];
                            r_bk_rb <= r_rb[sel];
                        end
                        if (!r_rb[sel] && (!r_sany || r_lt[sel] < r_sc_lt)) begin
                            r_sany  <= 1'b1;
                            r_sv    <= sel;
                            r_sc_lt <= r_lt[sel];
                        end
                        r_idx <= r_idx + NW'(1);
                    end
                end
                S_SCCLR: begin
                    if (r_idx == n_frames) begin
                        r_state <= fin_state;
                    end else begin
                        if (!r_sany || r_lt[sel] < r_sc_lt ||
                            (r_lt[sel] == r_sc_lt && sel < r_sv)) begin
                            r_rb[sel] <= 1'b0;
                        end
                        r_idx <= r_idx + NW'(1);
                    end
                end
                S_CMOD: begin
                    if (r_idx >= n_frames) begin
                        r_idx <= r_idx - n_frames;
                    end else begin
                        r_state <= S_CLK;
                    end
                end
                S_CLK: begin
                    if (!r_rb[sel]) begin
                        r_dest  <= sel;
                        r_hand  <= idx_inc[FW-1:0];
                        r_state <= fin_state;
                    end else begin
                        r_rb[sel] <= 1'b0;
                        r_idx     <= idx_inc;
                    end
                end
                S_MOD: begin
                    if (r_mcnt == MW'(CW)) begin
                        r_state <= S_UPD;
                    end else begin
                        r_rem  <= (rem2 >= n_frames) ? rem2 - n_frames : rem2;
                        r_dvd  <= {r_dvd[CW-2:0], 1'b0};
                        r_mcnt <= r_mcnt + MW'(1);
                    end
                end
                S_UPD: begin
                    if (!r_ov || i_out_ready) begin
                        r_out.hit           <= r_hit;
                        r_out.frame         <= 4'(r_dest);
                        r_out.evicted_valid <= r_ev;
                        r_out.evicted_page  <= r_ev ? 16'(r_fp[r_dest]) : '0;
                        r_out.ref_page      <= 16'(r_pg);
                        r_out.hit_count     <= r_hit ? hits_inc : r_hits;
                        r_out.miss_count    <= r_hit ? r_miss : miss_inc;
                        r_ov <= 1'b1;
                        if (r_hit) begin
                            r_hits <= hits_inc;
                        end else begin
                            r_miss         <= miss_inc;
                            r_fv[r_dest]   <= 1'b1;
                            r_fp[r_dest]   <= r_pg;
                            r_lt[r_dest]   <= r_pos;
                        end
                        r_lu[r_dest] <= r_pos;
                        // nru period end clears the class bit of every frame in use, the new one too
                        if (r_policy == pre_pkg::P_NRU && r_rem == '0) begin
                            for (int k = 0; k < FS; k++) begin
                                if (NW'(k) < n_frames) begin
                                    r_rb[k] <= 1'b0;
                                end
                            end
                        end else begin
                            r_rb[r_dest] <= 1'b1;
                        end
                        r_pos   <= r_pos + CW'(1);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
